### sv/scl_pkg.sv
// package for the serial command line parser
// holds types, character codes and command codes shared by all modules
// no dependencies
package scl_pkg;

  // default line buffer capacity, in characters
  localparam int unsigned LineCapacityDef = 32;
  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 2;

  // send: width of the id field below the length field
  localparam int unsigned IdBits = 29;

  // ascii codes used by the decoder
  localparam logic [7:0] AsciiLf     = 8'h0A;
  localparam logic [7:0] AsciiCr     = 8'h0D;
  localparam logic [7:0] AsciiZero   = 8'h30;
  localparam logic [7:0] AsciiNine   = 8'h39;
  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiUpperF = 8'h46;
  localparam logic [7:0] AsciiLowerA = 8'h61;
  localparam logic [7:0] AsciiLowerF = 8'h66;
  localparam logic [7:0] AsciiLowerZ = 8'h7A;
  localparam logic [7:0] AsciiCaseOff = 8'h20;
  localparam logic [7:0] AsciiB = 8'h42;
  localparam logic [7:0] AsciiF = 8'h46;
  localparam logic [7:0] AsciiI = 8'h49;
  localparam logic [7:0] AsciiS = 8'h53;
  localparam logic [7:0] AsciiV = 8'h56;

  // command codes of a result
  typedef enum logic [2:0] {
    CmdVersion = 3'd0,
    CmdBaud    = 3'd1,
    CmdFilter  = 3'd2,
    CmdId      = 3'd3,
    CmdSend    = 3'd4,
    CmdUnknown = 3'd5
  } cmd_e;

  // one classified character, as queued between front and back
  typedef struct packed {
    logic       eol;     // cr or lf
    logic       cr;      // cr
    cmd_e       cmd;     // command this character selects as a lead character
    logic [3:0] digit;   // hex value, zero for non-hex
  } item_t;

  // one result
  typedef struct packed {
    cmd_e        command;
    logic [31:0] param_one;
    logic [31:0] param_two;
    logic [31:0] param_three;
    logic        cr_requested;
  } result_t;

endpackage

### sv/scl_if.sv
// channel interfaces for the serial command line parser
// valid/ready handshake, one request moves when both are high
// no dependencies
interface scl_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scl_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] param_one;
  logic [31:0] param_two;
  logic [31:0] param_three;
  logic        cr_requested;

  modport source (
    output valid, output command, output param_one, output param_two,
    output param_three, output cr_requested, input ready
  );
  modport sink (
    input valid, input command, input param_one, input param_two,
    input param_three, input cr_requested, output ready
  );
endinterface

### sv/scl_front.sv
// front part: accepts received characters and classifies them
// depends on scl_pkg and scl_if
module scl_front (
  scl_rx_if.sink        rx_i,
  input  logic          full_i,
  output logic          push_o,
  output scl_pkg::item_t item_o
);
  import scl_pkg::*;

  logic [7:0] upper;

  // take a request whenever the queue has room
  assign rx_i.ready = !full_i;
  assign push_o     = rx_i.valid && !full_i;

  // fold lower case letters to upper case for the command decode
  always_comb begin
    upper = rx_i.rx_byte;
    if (rx_i.rx_byte inside {[AsciiLowerA:AsciiLowerZ]}) begin
      upper = rx_i.rx_byte - AsciiCaseOff;
    end
  end

  // classify the character
  always_comb begin
    item_o.eol = (rx_i.rx_byte == AsciiCr) || (rx_i.rx_byte == AsciiLf);
    item_o.cr  = (rx_i.rx_byte == AsciiCr);

    case (upper)
      AsciiV:  item_o.cmd = CmdVersion;
      AsciiB:  item_o.cmd = CmdBaud;
      AsciiF:  item_o.cmd = CmdFilter;
      AsciiI:  item_o.cmd = CmdId;
      AsciiS:  item_o.cmd = CmdSend;
      default: item_o.cmd = CmdUnknown;
    endcase

    item_o.digit = 4'd0;
    if (rx_i.rx_byte inside {[AsciiZero:AsciiNine]}) begin
      item_o.digit = 4'(rx_i.rx_byte - AsciiZero);
    end else if (rx_i.rx_byte inside {[AsciiUpperA:AsciiUpperF]}) begin
      item_o.digit = 4'(rx_i.rx_byte - AsciiUpperA + 8'd10);
    end else if (rx_i.rx_byte inside {[AsciiLowerA:AsciiLowerF]}) begin
      item_o.digit = 4'(rx_i.rx_byte - AsciiLowerA + 8'd10);
    end
  end

endmodule

### sv/scl_fifo.sv
// short queue of classified characters between front and back
// depends on scl_pkg
module scl_fifo #(
  parameter int unsigned Depth = scl_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scl_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output scl_pkg::item_t item_o,
  output logic           empty_o
);
  import scl_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

### sv/scl_back.sv
// back part: assembles the command line and decodes it at end of line
// depends on scl_pkg and scl_if
module scl_back #(
  parameter int unsigned LineCapacity = scl_pkg::LineCapacityDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  scl_pkg::item_t item_i,
  output logic           pop_o,
  scl_res_if.source      res_o
);
  import scl_pkg::*;

  localparam int unsigned LenW = $clog2(LineCapacity);

  logic [LenW-1:0] len_q, len_d;
  cmd_e            lead_q, lead_d;
  logic [3:0]      slot_q, slot_d;
  logic [31:0]     w1_q, w1_d;
  logic [31:0]     w2_q, w2_d;
  logic [31:0]     w3_q, w3_d;
  logic            cr_q, cr_d;
  logic            vld_q, vld_d;
  result_t         res_q, res_d;

  logic [2:0]      nib;
  logic [31:0]     shifted;
  logic [2:0]      len_m1;
  logic            room;

  // advance when the output register is free or being drained
  assign pop_o = !empty_i && (!vld_q || res_o.ready);

  // nibble place in a word, most significant first; word positions start at 2, 10, 18
  assign nib     = 3'(3'd7 - (len_q[2:0] - 3'd2));
  assign shifted = {28'd0, item_i.digit} << {nib, 2'b00};
  assign room    = ({1'b0, len_q} + 1'b1) < (LenW + 1)'(LineCapacity);
  // send length field: a zero digit counts as length one
  assign len_m1  = (slot_q == 4'd0) ? 3'd0 : 3'(slot_q - 4'd1);

  // line update and result decode
  always_comb begin
    len_d  = len_q;
    lead_d = lead_q;
    slot_d = slot_q;
    w1_d   = w1_q;
    w2_d   = w2_q;
    w3_d   = w3_q;
    cr_d   = cr_q;
    vld_d  = vld_q && !res_o.ready;
    res_d  = res_q;

    if (pop_o) begin
      cr_d = cr_q | item_i.cr;
      if (item_i.eol) begin
        if (len_q != '0) begin
          vld_d              = 1'b1;
          res_d.command      = lead_q;
          res_d.param_one    = '0;
          res_d.param_two    = '0;
          res_d.param_three  = '0;
          res_d.cr_requested = cr_q | item_i.cr;
          case (lead_q)
            CmdBaud: begin
              res_d.param_one = w1_q;
            end
            CmdFilter, CmdId: begin
              res_d.param_one = {28'd0, slot_q};
              res_d.param_two = w1_q;
            end
            CmdSend: begin
              res_d.param_one   = {len_m1, w1_q[IdBits-1:0]};
              res_d.param_two   = w2_q;
              res_d.param_three = w3_q;
            end
            default: begin
            end
          endcase
        end
        // clear the line
        len_d  = '0;
        lead_d = CmdUnknown;
        slot_d = '0;
        w1_d   = '0;
        w2_d   = '0;
        w3_d   = '0;
      end else if (room) begin
        if (len_q == LenW'(0)) begin
          lead_d = item_i.cmd;
        end else if (len_q == LenW'(1)) begin
          slot_d = item_i.digit;
        end else if (len_q < LenW'(10)) begin
          w1_d = w1_q | shifted;
        end else if (len_q < LenW'(18)) begin
          w2_d = w2_q | shifted;
        end else if (len_q < LenW'(26)) begin
          w3_d = w3_q | shifted;
        end
        len_d = len_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      lead_q <= CmdUnknown;
      slot_q <= '0;
      w1_q   <= '0;
      w2_q   <= '0;
      w3_q   <= '0;
      cr_q   <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      len_q  <= len_d;
      lead_q <= lead_d;
      slot_q <= slot_d;
      w1_q   <= w1_d;
      w2_q   <= w2_d;
      w3_q   <= w3_d;
      cr_q   <= cr_d;
      vld_q  <= vld_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o.valid        = vld_q;
  assign res_o.command      = res_q.command;
  assign res_o.param_one    = res_q.param_one;
  assign res_o.param_two    = res_q.param_two;
  assign res_o.param_three  = res_q.param_three;
  assign res_o.cr_requested = res_q.cr_requested;

endmodule

### sv/serial_command_line_parser.sv
// top level of the serial command line parser
// depends on scl_pkg, scl_if, scl_front, scl_fifo and scl_back

// Takes one received character per cycle and returns one result per non-empty line,
// when a CR or LF arrives. The front classifies each character (line end, command
// letter, hex value) and queues it; the back updates the line state and decodes the
// line. Sustained rate is one character per clock while results are taken, set by the
// back's line update; a result is presented in an output register, written when its
// line-ending character is taken from the queue. While a result waits the back holds,
// the queue fills and the input then stalls until the result is taken.
// Characters beyond LineCapacity - 1 in a line are dropped; empty lines give nothing.
module serial_command_line_parser #(
  parameter int unsigned LineCapacity = scl_pkg::LineCapacityDef,
  parameter int unsigned QueueDepth   = scl_pkg::QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  scl_rx_if.sink    rx_i,
  scl_res_if.source res_o
);
  import scl_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  logic  empty;
  item_t front_item;
  item_t back_item;

  // classification
  scl_front u_front (
    .rx_i   (rx_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  // queue between the two parts
  scl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (back_item),
    .empty_o (empty)
  );

  // line assembly and decode
  scl_back #(
    .LineCapacity (LineCapacity)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .item_i  (back_item),
    .pop_o   (pop),
    .res_o   (res_o)
  );

  // a new result only follows a character taken from the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(pop))
    else $error("result appeared without a dequeued character");

  // only send carries a third parameter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.command != CmdSend) |-> (res_o.param_three == '0))
    else $error("third parameter set for a non-send command");

  // version and unknown carry no parameters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.command == CmdVersion || res_o.command == CmdUnknown))
      |-> (res_o.param_one == '0 && res_o.param_two == '0))
    else $error("parameters set for version or unknown command");

endmodule
